[rtl/core/swm_pkg.sv]
package swm_pkg;

  // default build sizes
  localparam int WINDOW_MAX_DEF   = 15;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // window size register
  localparam int                  CFG_WIDTH = 4;
  localparam logic [CFG_WIDTH-1:0] CFG_RESET = 4'd3;

  // control handed from the sequencer to the sort chain
  typedef struct packed {
    logic load;   // capture a new window snapshot
    logic run;    // perform one compare-exchange round
    logic odd;    // round parity: pairs start at odd cells
  } sort_ctl_t;

endpackage

[rtl/core/sliding_window_median_filter.sv]
// Order: an accepted sample owing a median goes to S_SORT, then S_EMIT; one owing
//   only pass-through results goes to S_EMIT; one owing none stays in S_IDLE.
// Flow: the input stalls outside S_IDLE, so no new sample is taken until every result
//   owed by the last has gone out. W, the count of sort rounds, is the effective window.
// Reset: synchronous, active low; clears the position count, sequencer and output
//   valid, sets the window to 3. History holds no value until written.
module sliding_window_median_filter
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input samples
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_end_of_sequence,
  // results
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_value,
  output logic                           out_filtered,
  output logic                           out_run_last,
  // window size register
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_WIDTH-1:0]           cfg_window_size
);

  localparam int CW  = $clog2(WINDOW_MAX + 1);
  localparam int DW  = $clog2(WINDOW_MAX);
  localparam int TOP = (WINDOW_MAX % 2 == 1) ? WINDOW_MAX : WINDOW_MAX - 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SORT,
    S_EMIT
  } state_t;

  state_t                         state_r, state_nxt;
  logic [CFG_WIDTH-1:0]           cfg_r;
  logic [CW-1:0]                  seen_r, seen_nxt;
  logic [CW-1:0]                  cnt_r, cnt_nxt;
  logic [CW-1:0]                  w_r, w_nxt;
  logic [DW-1:0]                  h_r, h_nxt;
  logic [DW-1:0]                  d_r, d_nxt;
  logic                           med_r, med_nxt;
  logic                           eos_r, eos_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_value_r;
  logic                           out_filtered_r;
  logic                           out_run_last_r;
  logic signed [SAMPLE_WIDTH-1:0] history_r [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] snap      [WINDOW_MAX];

  logic [CFG_WIDTH-1:0]           w_odd;
  logic [CW-1:0]                  w_eff;
  logic [CW-1:0]                  h_eff;
  logic [CW-1:0]                  seen_inc;
  logic [CW-1:0]                  k;
  logic                           has_out;
  logic [DW-1:0]                  d_start;
  logic                           med_start;
  logic                           in_fire;
  logic                           emit_fire;
  logic                           emit_last;
  sort_ctl_t                      sort_ctl;
  logic signed [SAMPLE_WIDTH-1:0] median;

  assign in_fire   = in_valid && !in_stall;
  assign emit_fire = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
  assign emit_last = !eos_r || (d_r == '0);

  // round the window down to odd and clamp it
  always_comb begin
    w_odd = cfg_r;
    if (!cfg_r[0] && (cfg_r != '0)) begin
      w_odd = cfg_r - 1'b1;
    end
    if (w_odd < CFG_WIDTH'(3)) begin
      w_eff = CW'(3);
    end else if (int'(w_odd) > TOP) begin
      w_eff = CW'(TOP);
    end else begin
      w_eff = CW'(w_odd);
    end
    h_eff = (w_eff - 1'b1) >> 1;
  end

  // position of the new sample and the first result it owes
  always_comb begin
    seen_inc  = (seen_r < CW'(WINDOW_MAX)) ? seen_r + 1'b1 : seen_r;
    k         = seen_inc - 1'b1;
    has_out   = in_end_of_sequence || (k >= h_eff);
    d_start   = (in_end_of_sequence && (k < h_eff)) ? DW'(k) : DW'(h_eff);
    med_start = (d_start == DW'(h_eff)) && ({1'b0, k} >= {h_eff, 1'b0});
  end

  // window as it stands after the shift, newest first
  always_comb begin
    snap[0] = in_sample;
    for (int i = 1; i < WINDOW_MAX; i++) begin
      snap[i] = history_r[i-1];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    seen_nxt  = seen_r;
    cnt_nxt   = cnt_r;
    w_nxt     = w_r;
    h_nxt     = h_r;
    d_nxt     = d_r;
    med_nxt   = med_r;
    eos_nxt   = eos_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          seen_nxt = in_end_of_sequence ? '0 : seen_inc;
          w_nxt    = w_eff;
          h_nxt    = DW'(h_eff);
          d_nxt    = d_start;
          med_nxt  = med_start;
          eos_nxt  = in_end_of_sequence;
          cnt_nxt  = '0;
          if (has_out) begin
            state_nxt = med_start ? S_SORT : S_EMIT;
          end
        end
      end
      S_SORT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == w_r - 1'b1) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_fire) begin
          med_nxt = 1'b0;
          if (emit_last) begin
            state_nxt = S_IDLE;
          end else begin
            d_nxt = d_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // hold the result until taken
  always_comb begin
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seen_r      <= '0;
      cfg_r       <= CFG_RESET;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      w_r         <= CW'(3);
      h_r         <= DW'(1);
      d_r         <= '0;
      med_r       <= 1'b0;
      eos_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      w_r         <= w_nxt;
      h_r         <= h_nxt;
      d_r         <= d_nxt;
      med_r       <= med_nxt;
      eos_r       <= eos_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_window_size;
      end
    end
  end

  // advance the history on each accepted sample; load result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
        history_r[i] <= snap[i];
      end
    end
    if (emit_fire) begin
      out_value_r    <= med_r ? median : history_r[d_r];
      out_filtered_r <= med_r;
      out_run_last_r <= emit_last;
    end
  end

  // sort chain works on a snapshot taken at accept
  assign sort_ctl.load = in_fire;
  assign sort_ctl.run  = (state_r == S_SORT);
  assign sort_ctl.odd  = cnt_r[0];

  swm_sort_chain #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .CW          (CW),
    .DW          (DW)
  ) u_chain (
    .clk      (clk),
    .ctl      (sort_ctl),
    .width    (w_r),
    .load_vals(snap),
    .sel      (h_r),
    .median   (median)
  );

  assign in_stall     = (state_r != S_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_filtered = out_filtered_r;
  assign out_run_last = out_run_last_r;

endmodule

[rtl/core/swm_sort_cell.sv]
module swm_sort_cell
  import swm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           load,
  input  logic signed [SAMPLE_WIDTH-1:0] load_val,
  input  logic                           act_lo,
  input  logic                           act_hi,
  input  logic signed [SAMPLE_WIDTH-1:0] left_val,
  input  logic signed [SAMPLE_WIDTH-1:0] right_val,
  output logic signed [SAMPLE_WIDTH-1:0] val
);

  logic signed [SAMPLE_WIDTH-1:0] val_r;
  logic signed [SAMPLE_WIDTH-1:0] val_nxt;

  // keep the smaller value as the lower cell of a pair, the larger as the upper
  always_comb begin
    val_nxt = val_r;
    if (load) begin
      val_nxt = load_val;
    end else if (act_lo) begin
      val_nxt = (right_val < val_r) ? right_val : val_r;
    end else if (act_hi) begin
      val_nxt = (left_val > val_r) ? left_val : val_r;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

[rtl/core/swm_sort_chain.sv]
module swm_sort_chain
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int CW           = $clog2(WINDOW_MAX + 1),
  parameter int DW           = $clog2(WINDOW_MAX)
) (
  input  logic                           clk,
  input  sort_ctl_t                      ctl,
  input  logic [CW-1:0]                  width,
  input  logic signed [SAMPLE_WIDTH-1:0] load_vals [WINDOW_MAX],
  input  logic [DW-1:0]                  sel,
  output logic signed [SAMPLE_WIDTH-1:0] median
);

  logic signed [SAMPLE_WIDTH-1:0] vals [WINDOW_MAX];

  // row of odd-even transposition cells; only pairs inside the window trade
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic                           act_lo;
    logic                           act_hi;
    logic signed [SAMPLE_WIDTH-1:0] left_val;
    logic signed [SAMPLE_WIDTH-1:0] right_val;

    assign act_lo = ctl.run && (ctl.odd == (i % 2 == 1)) && (int'(width) > i + 1);
    assign act_hi = ctl.run && (ctl.odd != (i % 2 == 1)) && (i >= 1) && (int'(width) > i);

    if (i == 0) begin : g_left_edge
      assign left_val = '0;
    end else begin : g_left
      assign left_val = vals[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_right_edge
      assign right_val = '0;
    end else begin : g_right
      assign right_val = vals[i+1];
    end

    swm_sort_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_cell (
      .clk      (clk),
      .load     (ctl.load),
      .load_val (load_vals[i]),
      .act_lo   (act_lo),
      .act_hi   (act_hi),
      .left_val (left_val),
      .right_val(right_val),
      .val      (vals[i])
    );
  end

  // pick the middle rank
  assign median = vals[sel];

endmodule

[rtl/core/swm_checker.sv]
module swm_checker
  import swm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           in_end_of_sequence,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic signed [SAMPLE_WIDTH-1:0] out_value,
  input logic                           out_filtered,
  input logic                           out_run_last
);

  // reset empties the output and frees the input
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("output valid or input stall after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_value) && $stable(out_filtered) && $stable(out_run_last)))
    else $error("stalled result changed");

  // an end of sequence always owes a result, so the input must close
  a_eos_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_end_of_sequence) |=> in_stall)
    else $error("input open after end of sequence transaction");

  // no new sample while a flush still has results to give
  a_flush_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_run_last) |-> in_stall)
    else $error("input open during flush");

endmodule

bind sliding_window_median_filter swm_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_swm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_end_of_sequence(in_end_of_sequence),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_value         (out_value),
  .out_filtered      (out_filtered),
  .out_run_last      (out_run_last)
);
